// ===== hdl/paged_slot_allocator_top_defines.svh =====
// Assertion macros for the paged slot allocator checker.
// Each macro expects signals named clk and rst_n in the scope where it is used.
`ifndef PAGED_SLOT_ALLOCATOR_TOP_DEFINES_SVH
`define PAGED_SLOT_ALLOCATOR_TOP_DEFINES_SVH

// Same-cycle implication, ignored while reset is asserted.
`define PSA_ASSERT_IMPLIES(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, ignored while reset is asserted.
`define PSA_ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hdl/psa_pkg.sv =====
// Shared types and constants for the paged slot allocator.
// No dependencies; the interfaces, the top level and the checker import this package.
`timescale 1ns / 1ps

package psa_pkg;

  localparam int KIND_W   = 2;
  localparam int PAGE_W   = 4;
  localparam int SLOT_W   = 5;
  localparam int STATUS_W = 2;
  localparam int CFG_W    = 6;

  localparam logic [CFG_W-1:0] CFG_RESET = 6'd32;

  // Slots examined by the search unit in one step.
  localparam int CHUNK_W = 8;

  typedef enum logic [KIND_W-1:0] {
    KIND_INSERT = 2'd0,
    KIND_DELETE = 2'd1,
    KIND_QUERY  = 2'd2
  } kind_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK           = 2'd0,
    ST_NO_RECORD    = 2'd1,
    ST_OUT_OF_RANGE = 2'd2,
    ST_NO_PAGE      = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    FSM_IDLE,
    FSM_READ,
    FSM_SCAN,
    FSM_DONE
  } fsm_t;

endpackage

// ===== hdl/psa_in_if.sv =====
// Request channel of the paged slot allocator: valid/ready plus request payload.
// Depends on psa_pkg for the field widths.
`timescale 1ns / 1ps

interface psa_in_if import psa_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [KIND_W-1:0] kind;
  logic [PAGE_W-1:0] page;
  logic [SLOT_W-1:0] slot;

  modport source (output valid, output kind, output page, output slot, input ready);
  modport sink   (input valid, input kind, input page, input slot, output ready);
endinterface

// ===== hdl/psa_out_if.sv =====
// Result channel of the paged slot allocator: valid/ready plus result payload.
// Depends on psa_pkg for the field widths.
`timescale 1ns / 1ps

interface psa_out_if import psa_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [STATUS_W-1:0] status;
  logic [PAGE_W-1:0]   out_page;
  logic [SLOT_W-1:0]   out_slot;

  modport source (output valid, output status, output out_page, output out_slot, input ready);
  modport sink   (input valid, input status, input out_page, input out_slot, output ready);
endinterface

// ===== hdl/paged_slot_allocator_top.sv =====
// Sequence: delete and query read the page row and then register the result; early rejects
//   skip the row read. Insert reads the row, then scans the occupancy bitmap for a free slot.
// Throughput: one beat at a time; the next input beat is taken the cycle after the result
//   is registered. Insert time is set by the 8-slot search unit that steps over the bitmap.
// Reset: synchronous, active low. The page table has no clearing pass; pages at or above
//   the allocation count read as empty, so the block is ready in the first cycle after reset.
`timescale 1ns / 1ps

module paged_slot_allocator_top import psa_pkg::*; #(
  parameter int NUM_PAGES      = 16,
  parameter int SLOTS_PER_PAGE = 32
) (
  input  logic             clk,
  input  logic             rst_n,
  psa_in_if.sink           in_ch,
  psa_out_if.source        out_ch,
  input  logic             cfg_we,
  input  logic [CFG_W-1:0] cfg_wdata
);

  // Widths derived from the page and slot counts.
  localparam int PIW  = $clog2(NUM_PAGES);            // page index
  localparam int PCW  = $clog2(NUM_PAGES + 1);        // allocation count
  localparam int SIW  = $clog2(SLOTS_PER_PAGE);       // slot index
  localparam int CW   = $clog2(SLOTS_PER_PAGE + 1);   // record count and capacity
  localparam int CXW  = (CW > CFG_W) ? CW : CFG_W;    // capacity compares
  localparam int PGW  = (PCW > PAGE_W) ? PCW : PAGE_W; // page-number compares
  localparam int NCH  = (SLOTS_PER_PAGE + CHUNK_W - 1) / CHUNK_W; // search steps per page
  localparam int WW   = NCH * CHUNK_W;                 // search window, padded
  localparam int NCW  = $clog2(NCH + 1);
  localparam int BW   = $clog2(WW + 1);
  localparam int POSW = $clog2(CHUNK_W);

  localparam logic [WW-1:0] WIN_ONES = '1;

  // One row of the page table. All per-page state lives in a single row so that
  // each request is one read at the start and at most one write at the end.
  typedef struct packed {
    logic [SLOTS_PER_PAGE-1:0] occ;
    logic [CW-1:0]             cnt;
    logic                      on_list;
    logic [PIW-1:0]            nxt;
    logic                      nxt_valid;
  } row_t;

  row_t page_mem [NUM_PAGES];
  row_t rd_row_r;
  row_t row_eff;

  // Sequencer and list state.
  fsm_t             state_r, state_nxt;
  logic [CFG_W-1:0] slots_in_use_r;
  logic [PIW-1:0]   head_r;
  logic             head_valid_r;
  logic [PCW-1:0]   alloc_r;

  // Request held while it is worked on.
  logic [KIND_W-1:0] kind_r, kind_nxt;
  logic [SLOT_W-1:0] slot_r, slot_nxt;
  logic [PIW-1:0]    addr_r, addr_nxt;
  logic              fresh_r, fresh_nxt;

  // Search unit.
  logic [WW-1:0]      win_r, win_nxt, win_load;
  logic [BW-1:0]      base_r, base_nxt;
  logic [NCW-1:0]     step_r, step_nxt;
  logic               first_r, first_nxt;
  logic [SIW-1:0]     found_r, found_nxt;
  logic [CHUNK_W-1:0] chunk;
  logic               chunk_clear;
  logic [POSW-1:0]    pos;

  // Update staged for the commit cycle.
  logic              wr_r, wr_nxt;
  row_t              wrow_r, wrow_nxt;
  logic              head_upd_r, head_upd_nxt;
  logic [PIW-1:0]    head_new_r, head_new_nxt;
  logic              head_new_v_r, head_new_v_nxt;
  logic              alloc_inc_r, alloc_inc_nxt;
  status_t           res_status_r, res_status_nxt;
  logic [PAGE_W-1:0] res_page_r, res_page_nxt;
  logic [SLOT_W-1:0] res_slot_r, res_slot_nxt;

  // Output register.
  logic                out_valid_r;
  logic [STATUS_W-1:0] out_status_r;
  logic [PAGE_W-1:0]   out_page_r;
  logic [SLOT_W-1:0]   out_slot_r;

  logic [CW-1:0] cap;
  logic          count_full;
  logic          unlink;
  logic          early_done;
  logic          scan_end;
  logic          in_ready;
  logic          accept;
  logic          commit;

  // Effective capacity: the register clamped to the range 1 .. SLOTS_PER_PAGE.
  always_comb begin
    if (CXW'(slots_in_use_r) > CXW'(SLOTS_PER_PAGE)) begin
      cap = CW'(SLOTS_PER_PAGE);
    end else if (slots_in_use_r == '0) begin
      cap = CW'(1);
    end else begin
      cap = CW'(slots_in_use_r);
    end
  end

  // A freshly allocated page was never written; it reads as empty and already listed.
  always_comb begin
    row_eff = rd_row_r;
    if (fresh_r) begin
      row_eff         = '0;
      row_eff.on_list = 1'b1;
    end
  end

  // Search window: slots at or above the capacity look occupied, as does the padding.
  always_comb begin
    win_load = WIN_ONES;
    for (int i = 0; i < SLOTS_PER_PAGE; i++) begin
      win_load[i] = row_eff.occ[i] | (i >= int'(cap));
    end
  end

  // The shared search unit: lowest clear bit of the low chunk of the window.
  always_comb begin
    chunk       = win_r[CHUNK_W-1:0];
    chunk_clear = ~&chunk;
    pos         = '0;
    for (int i = CHUNK_W - 1; i >= 0; i--) begin
      if (!chunk[i]) begin
        pos = POSW'(i);
      end
    end
  end

  // After the insert the page is full once its count reaches the capacity.
  assign count_full = (CXW'(row_eff.cnt) + CXW'(1)) >= CXW'(cap);

  // Sequencer outputs.
  always_comb begin
    in_ready = (state_r == FSM_IDLE);
    accept   = in_ch.valid && in_ready;
    commit   = (state_r == FSM_DONE) && (!out_valid_r || out_ch.ready);
  end

  // Sequencer next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      FSM_IDLE: begin
        if (accept) begin
          state_nxt = early_done ? FSM_DONE : FSM_READ;
        end
      end
      FSM_READ: begin
        state_nxt = (kind_r == KIND_INSERT) ? FSM_SCAN : FSM_DONE;
      end
      FSM_SCAN: begin
        if (scan_end) begin
          state_nxt = FSM_DONE;
        end
      end
      FSM_DONE: begin
        if (commit) begin
          state_nxt = FSM_IDLE;
        end
      end
      default: begin
        state_nxt = FSM_IDLE;
      end
    endcase
  end

  // Request datapath.
  always_comb begin
    kind_nxt       = kind_r;
    slot_nxt       = slot_r;
    addr_nxt       = addr_r;
    fresh_nxt      = fresh_r;
    win_nxt        = win_r;
    base_nxt       = base_r;
    step_nxt       = step_r;
    first_nxt      = first_r;
    found_nxt      = found_r;
    wr_nxt         = wr_r;
    wrow_nxt       = wrow_r;
    head_upd_nxt   = head_upd_r;
    head_new_nxt   = head_new_r;
    head_new_v_nxt = head_new_v_r;
    alloc_inc_nxt  = alloc_inc_r;
    res_status_nxt = res_status_r;
    res_page_nxt   = res_page_r;
    res_slot_nxt   = res_slot_r;
    early_done     = 1'b0;
    scan_end       = 1'b0;
    unlink         = 1'b0;

    case (state_r)
      FSM_IDLE: begin
        if (accept) begin
          kind_nxt       = in_ch.kind;
          slot_nxt       = in_ch.slot;
          addr_nxt       = PIW'(in_ch.page);
          fresh_nxt      = 1'b0;
          wr_nxt         = 1'b0;
          head_upd_nxt   = 1'b0;
          alloc_inc_nxt  = 1'b0;
          res_status_nxt = ST_OK;
          res_page_nxt   = in_ch.page;
          res_slot_nxt   = in_ch.slot;
          case (in_ch.kind)
            KIND_INSERT: begin
              if (head_valid_r) begin
                addr_nxt = head_r;
              end else if (alloc_r < PCW'(NUM_PAGES)) begin
                addr_nxt  = PIW'(alloc_r);
                fresh_nxt = 1'b1;
              end else begin
                early_done     = 1'b1;
                res_status_nxt = ST_NO_PAGE;
                res_page_nxt   = '0;
                res_slot_nxt   = '0;
              end
            end
            KIND_DELETE, KIND_QUERY: begin
              if (PGW'(in_ch.page) >= PGW'(alloc_r)) begin
                early_done     = 1'b1;
                res_status_nxt = ST_NO_RECORD;
              end
            end
            default: begin
              early_done     = 1'b1;
              res_status_nxt = ST_OUT_OF_RANGE;
            end
          endcase
        end
      end

      FSM_READ: begin
        if (kind_r == KIND_INSERT) begin
          win_nxt   = win_load;
          base_nxt  = '0;
          step_nxt  = '0;
          first_nxt = 1'b1;
        end else if (CXW'(slot_r) >= CXW'(cap)) begin
          res_status_nxt = ST_OUT_OF_RANGE;
        end else if (!row_eff.occ[SIW'(slot_r)]) begin
          res_status_nxt = ST_NO_RECORD;
        end else if (kind_r == KIND_DELETE) begin
          wr_nxt                     = 1'b1;
          wrow_nxt                   = row_eff;
          wrow_nxt.occ[SIW'(slot_r)] = 1'b0;
          if (row_eff.cnt != '0) begin
            wrow_nxt.cnt = row_eff.cnt - CW'(1);
          end
          if (!row_eff.on_list) begin
            wrow_nxt.on_list   = 1'b1;
            wrow_nxt.nxt       = head_r;
            wrow_nxt.nxt_valid = head_valid_r;
            head_upd_nxt       = 1'b1;
            head_new_nxt       = addr_r;
            head_new_v_nxt     = 1'b1;
          end
        end
      end

      FSM_SCAN: begin
        if (chunk_clear && first_r) begin
          // First clear slot: claim it, then look on for a second one.
          found_nxt = SIW'(base_r + BW'(pos));
          win_nxt   = win_r | (WW'(1) << pos);
          first_nxt = 1'b0;
        end else if (chunk_clear || step_r == NCW'(NCH - 1)) begin
          scan_end      = 1'b1;
          wr_nxt        = 1'b1;
          wrow_nxt      = row_eff;
          alloc_inc_nxt = fresh_r;
          res_page_nxt  = PAGE_W'(addr_r);
          if (first_r) begin
            // The head page has no room below the capacity.
            res_status_nxt = ST_NO_PAGE;
            res_slot_nxt   = '0;
            unlink         = 1'b1;
          end else begin
            res_status_nxt        = ST_OK;
            res_slot_nxt          = SLOT_W'(found_r);
            wrow_nxt.occ[found_r] = 1'b1;
            wrow_nxt.cnt          = row_eff.cnt + CW'(1);
            unlink                = !chunk_clear || count_full;
          end
          if (unlink) begin
            wrow_nxt.on_list = 1'b0;
            head_upd_nxt     = 1'b1;
            head_new_nxt     = row_eff.nxt;
            head_new_v_nxt   = row_eff.nxt_valid;
          end else if (fresh_r) begin
            head_upd_nxt   = 1'b1;
            head_new_nxt   = addr_r;
            head_new_v_nxt = 1'b1;
          end else begin
            head_upd_nxt = 1'b0;
          end
        end else begin
          // Nothing clear here: slide the next chunk in, padding with occupied bits.
          win_nxt  = (win_r >> CHUNK_W) | ~(WIN_ONES >> CHUNK_W);
          base_nxt = base_r + BW'(CHUNK_W);
          step_nxt = step_r + NCW'(1);
        end
      end

      FSM_DONE: begin
      end

      default: begin
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r        <= FSM_IDLE;
      slots_in_use_r <= CFG_RESET;
      head_r         <= '0;
      head_valid_r   <= 1'b0;
      alloc_r        <= '0;
      out_valid_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_we) begin
        slots_in_use_r <= cfg_wdata;
      end
      if (commit && head_upd_r) begin
        head_r       <= head_new_r;
        head_valid_r <= head_new_v_r;
      end
      if (commit && alloc_inc_r) begin
        alloc_r <= alloc_r + PCW'(1);
      end
      if (commit) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    kind_r       <= kind_nxt;
    slot_r       <= slot_nxt;
    addr_r       <= addr_nxt;
    fresh_r      <= fresh_nxt;
    win_r        <= win_nxt;
    base_r       <= base_nxt;
    step_r       <= step_nxt;
    first_r      <= first_nxt;
    found_r      <= found_nxt;
    wr_r         <= wr_nxt;
    wrow_r       <= wrow_nxt;
    head_upd_r   <= head_upd_nxt;
    head_new_r   <= head_new_nxt;
    head_new_v_r <= head_new_v_nxt;
    alloc_inc_r  <= alloc_inc_nxt;
    res_status_r <= res_status_nxt;
    res_page_r   <= res_page_nxt;
    res_slot_r   <= res_slot_nxt;
    if (commit) begin
      out_status_r <= res_status_r;
      out_page_r   <= res_page_r;
      out_slot_r   <= res_slot_r;
    end
  end

  // Page table: one row read when the beat is taken, at most one row written at commit.
  always_ff @(posedge clk) begin
    if (accept) begin
      rd_row_r <= page_mem[addr_nxt];
    end
    if (commit && wr_r) begin
      page_mem[addr_r] <= wrow_r;
    end
  end

  assign in_ch.ready     = in_ready;
  assign out_ch.valid    = out_valid_r;
  assign out_ch.status   = out_status_r;
  assign out_ch.out_page = out_page_r;
  assign out_ch.out_slot = out_slot_r;

endmodule

// ===== hdl/psa_chk.sv =====
// Port-level checker for the paged slot allocator, bound to the top level.
// Depends on psa_pkg and the assertion macros in paged_slot_allocator_top_defines.svh.
`timescale 1ns / 1ps
`include "paged_slot_allocator_top_defines.svh"

module psa_chk import psa_pkg::*; (
  input logic                clk,
  input logic                rst_n,
  input logic                in_valid,
  input logic                in_ready,
  input logic                out_valid,
  input logic                out_ready,
  input logic [STATUS_W-1:0] out_status,
  input logic [PAGE_W-1:0]   out_page,
  input logic [SLOT_W-1:0]   out_slot
);

  // Only one request is in flight.
  `PSA_ASSERT_NEXT(a_busy_after_beat, in_valid && in_ready, !in_ready, "ready stayed high after an input beat")

  // A new result appears only at the end of work, never straight out of idle.
  `PSA_ASSERT_IMPLIES(a_result_after_work, $rose(out_valid), !$past(in_ready), "result raised while idle")

  // Every no-page result carries slot zero.
  `PSA_ASSERT_IMPLIES(a_no_page_slot, out_valid && (out_status == ST_NO_PAGE), out_slot == '0, "no-page result with nonzero slot")

  `PSA_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_status) && $stable(out_page) && $stable(out_slot), "stalled result changed")

endmodule

bind paged_slot_allocator_top psa_chk u_psa_chk (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_valid   (in_ch.valid),
  .in_ready   (in_ch.ready),
  .out_valid  (out_ch.valid),
  .out_ready  (out_ch.ready),
  .out_status (out_ch.status),
  .out_page   (out_ch.out_page),
  .out_slot   (out_ch.out_slot)
);
